// File: design/sfgc_pkg.sv
package sfgc_pkg;

	localparam int unsigned FINGERS = 5;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_THUMB_CAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd5;

	// gesture codes
	localparam logic [1:0] MODE_REST = 2'd0;
	localparam logic [1:0] MODE_ZOOM = 2'd1;
	localparam logic [1:0] MODE_MOVE = 2'd2;
	localparam logic [1:0] MODE_ROTATE = 2'd3;

	// tense patterns, bit 4 is the thumb
	localparam logic [FINGERS-1:0] MASK_ROTATE = 5'b01000;
	localparam logic [FINGERS-1:0] MASK_ZOOM = 5'b00111;
	localparam logic [FINGERS-1:0] MASK_MOVE = 5'b10011;

	localparam logic [VALUE_W-1:0] TOLERANCE_RESET = 16'd6;

	typedef logic [FINGERS-1:0][VALUE_W-1:0] readings_t;

	// one finished frame handed from the parser to the classifier
	typedef struct packed {
		readings_t readings;
		logic [COUNT_W-1:0] count;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: design/sfgc_byte_if.sv
interface sfgc_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// File: design/sfgc_cfg_if.sv
interface sfgc_cfg_if;
	logic valid;
	logic ready;
	logic [sfgc_pkg::CFG_IDX_W-1:0] index;
	logic [sfgc_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: design/sfgc_res_if.sv
interface sfgc_res_if;
	logic valid;
	logic ready;
	logic [1:0] gesture_mode;
	logic [sfgc_pkg::FINGERS-1:0] tense_mask;
	logic [sfgc_pkg::COUNT_W-1:0] values_read;

	modport source(output valid, output gesture_mode, output tense_mask, output values_read,
		input ready);
	modport sink(input valid, input gesture_mode, input tense_mask, input values_read,
		output ready);
endinterface

// File: design/sfgc_parser.sv
module sfgc_parser #(
	parameter int unsigned FRAME_LIMIT = 99,
	parameter int unsigned FIELD_COUNT = 19
) (
	input logic clk,
	input logic arst_n,
	sfgc_byte_if.sink rx,
	input sfgc_pkg::queue_status_t q_status,
	output logic push,
	output sfgc_pkg::frame_t push_frame
);
	localparam int unsigned POS_W = $clog2(FRAME_LIMIT + 1);

	localparam logic [2:0] PH_OPEN = 3'd0;
	localparam logic [2:0] PH_BLANK = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_HALT = 3'd4;

	localparam logic [7:0] CH_OPEN = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [2:0] phase_q, phase_n, phase_e;
	logic [sfgc_pkg::VALUE_W-1:0] acc_q, acc_n, acc_e, value;
	logic neg_q, neg_n, neg_e;
	logic [sfgc_pkg::COUNT_W-1:0] cnt_q, cnt_n, cnt_e;
	sfgc_pkg::readings_t pend_q, pend_n, fingers_q, fingers_n;
	logic [7:0] c;
	logic [3:0] digit_val;
	logic is_digit, is_blank, restart, accept, close;

	assign rx.ready = !q_status.full;
	assign accept = rx.valid && rx.ready;
	assign c = rx.rx_byte;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign digit_val = 4'(c - CH_ZERO);
	assign restart = pos_q >= POS_W'(FRAME_LIMIT);
	assign close = c == CH_CLOSE;

	always_comb begin
		phase_e = restart ? PH_OPEN : phase_q;
		acc_e = restart ? '0 : acc_q;
		neg_e = restart ? 1'b0 : neg_q;
		cnt_e = restart ? '0 : cnt_q;
		pos_n = (restart ? '0 : pos_q) + POS_W'(1);
		phase_n = phase_e;
		acc_n = acc_e;
		neg_n = neg_e;
		cnt_n = cnt_e;
		pend_n = pend_q;
		value = neg_e ? 16'(-acc_e) : acc_e;
		case (phase_e)
			PH_OPEN: begin
				phase_n = (c == CH_OPEN) ? PH_BLANK : PH_HALT;
			end
			PH_BLANK: begin
				if (is_blank) begin
					phase_n = PH_BLANK;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					neg_n = c == CH_MINUS;
					phase_n = PH_SIGNED;
				end else if (is_digit) begin
					acc_n = 16'(digit_val);
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_HALT;
				end
			end
			PH_SIGNED: begin
				if (is_digit) begin
					acc_n = 16'(digit_val);
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_HALT;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					// times ten as two shifts and an add, wrapping at 16 bits
					acc_n = (acc_e << 3) + (acc_e << 1) + 16'(digit_val);
				end else begin
					for (int i = 0; i < sfgc_pkg::FINGERS; i++) begin
						if (cnt_e == sfgc_pkg::COUNT_W'(i)) begin
							pend_n[i] = value;
						end
					end
					cnt_n = cnt_e + sfgc_pkg::COUNT_W'(1);
					acc_n = '0;
					neg_n = 1'b0;
					phase_n = (c == CH_COMMA && cnt_n < sfgc_pkg::COUNT_W'(FIELD_COUNT))
						? PH_BLANK : PH_HALT;
				end
			end
			default: begin
				phase_n = PH_HALT;
			end
		endcase
		fingers_n = fingers_q;
		for (int i = 0; i < sfgc_pkg::FINGERS; i++) begin
			if (cnt_n > sfgc_pkg::COUNT_W'(i)) begin
				fingers_n[i] = pend_n[i];
			end
		end
	end

	assign push = accept && close && (cnt_n != '0);
	assign push_frame.readings = fingers_n;
	assign push_frame.count = cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_OPEN;
			acc_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			fingers_q <= '0;
		end else if (accept) begin
			if (close) begin
				pos_q <= '0;
				phase_q <= PH_OPEN;
				acc_q <= '0;
				neg_q <= 1'b0;
				cnt_q <= '0;
				fingers_q <= fingers_n;
			end else begin
				pos_q <= pos_n;
				phase_q <= phase_n;
				acc_q <= acc_n;
				neg_q <= neg_n;
				cnt_q <= cnt_n;
			end
		end
	end

	// only entries below the count are ever read, so no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= pend_n;
		end
	end

endmodule

// File: design/sfgc_queue.sv
module sfgc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sfgc_pkg::frame_t push_frame,
	input logic pop,
	output sfgc_pkg::frame_t head,
	output sfgc_pkg::queue_status_t status
);
	sfgc_pkg::frame_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] fill_q;

	assign head = slot_q[rd_q];
	assign status.full = fill_q == 2'd2;
	assign status.empty = fill_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_frame;
		end
	end

endmodule

// File: design/sfgc_classifier.sv
module sfgc_classifier (
	input logic clk,
	input logic arst_n,
	sfgc_cfg_if.sink cfg,
	input sfgc_pkg::frame_t head,
	input sfgc_pkg::queue_status_t q_status,
	output logic pop,
	sfgc_res_if.source res
);
	logic [sfgc_pkg::CFG_DATA_W-1:0] cal_q [sfgc_pkg::FINGERS];
	logic [sfgc_pkg::VALUE_W-1:0] tol_q;
	logic [sfgc_pkg::VALUE_W-1:0] relax, span, norm, gap;
	logic [sfgc_pkg::FINGERS-1:0] mask;
	logic [1:0] mode;
	logic valid_q;
	logic [1:0] mode_q;
	logic [sfgc_pkg::FINGERS-1:0] mask_q;
	logic [sfgc_pkg::COUNT_W-1:0] count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfgc_pkg::FINGERS; i++) begin
				cal_q[i] <= '0;
			end
			tol_q <= sfgc_pkg::TOLERANCE_RESET;
		end else if (cfg.valid) begin
			for (int i = 0; i < sfgc_pkg::FINGERS; i++) begin
				if (cfg.index == sfgc_pkg::REG_THUMB_CAL + sfgc_pkg::CFG_IDX_W'(i)) begin
					cal_q[i] <= cfg.data;
				end
			end
			if (cfg.index == sfgc_pkg::REG_TOLERANCE) begin
				tol_q <= cfg.data[sfgc_pkg::VALUE_W-1:0];
			end
		end
	end

	always_comb begin
		mask = '0;
		relax = '0;
		span = '0;
		norm = '0;
		gap = '0;
		for (int i = 0; i < sfgc_pkg::FINGERS; i++) begin
			relax = cal_q[i][sfgc_pkg::VALUE_W-1:0];
			span = cal_q[i][sfgc_pkg::CFG_DATA_W-1:sfgc_pkg::VALUE_W];
			norm = head.readings[i] - relax;
			gap = span - norm;
			mask[sfgc_pkg::FINGERS-1-i] = $signed(gap) <= $signed(tol_q);
		end
		case (mask)
			sfgc_pkg::MASK_ROTATE: mode = sfgc_pkg::MODE_ROTATE;
			sfgc_pkg::MASK_ZOOM: mode = sfgc_pkg::MODE_ZOOM;
			sfgc_pkg::MASK_MOVE: mode = sfgc_pkg::MODE_MOVE;
			default: mode = sfgc_pkg::MODE_REST;
		endcase
	end

	assign pop = !q_status.empty && (!valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || res.ready) begin
			valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= mode;
			mask_q <= mask;
			count_q <= head.count;
		end
	end

	assign res.valid = valid_q;
	assign res.gesture_mode = mode_q;
	assign res.tense_mask = mask_q;
	assign res.values_read = count_q;

endmodule

// File: design/sensor_frame_gesture_classifier.sv
// glove sensor frame classifier: takes one ascii byte per beat on rx, frames
// text up to each ']' (restarting after FRAME_LIMIT bytes without one), parses
// '[' and comma separated signed decimals wrapping at 16 bits, and for every
// frame with at least one value gives one beat on res carrying the gesture,
// the five-finger tense mask and the number of values read. a byte is taken
// every cycle; rx only stalls when the two-entry frame queue is full, which
// happens only while res is held off. a result is offered on res after the
// beat that carried its ']' once it has passed the queue register and then
// the output register. calibration and tolerance go in through cfg, which
// is always ready and must only be written while no frame is in flight.
module sensor_frame_gesture_classifier #(
	parameter int unsigned FRAME_LIMIT = 99,
	parameter int unsigned FIELD_COUNT = 19
) (
	input logic clk,
	input logic arst_n,
	sfgc_byte_if.sink rx,
	sfgc_cfg_if.sink cfg,
	sfgc_res_if.source res
);
	// front to back handoff
	logic push;
	logic pop;
	sfgc_pkg::frame_t push_frame;
	sfgc_pkg::frame_t head;
	sfgc_pkg::queue_status_t q_status;

	// front: byte parser, holds the stored finger readings
	sfgc_parser #(
		.FRAME_LIMIT(FRAME_LIMIT),
		.FIELD_COUNT(FIELD_COUNT)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.q_status(q_status),
		.push(push),
		.push_frame(push_frame)
	);

	// two finished frames may wait here so each side stalls on its own
	sfgc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_frame(push_frame),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	// back: calibration compare, gesture decode and output register
	sfgc_classifier u_classifier (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.res(res)
	);

endmodule
